/* design/pts_pkg.sv */
// Package for the priority task scheduler: operation codes, task states,
// configuration register indexes and the result record. No dependencies.
`default_nettype none

package pts_pkg;

    // Operation codes carried on the input channel
    typedef enum logic [2:0] {
        OP_ACTIVATE  = 3'd0,
        OP_TERMINATE = 3'd1,
        OP_CHAIN     = 3'd2,
        OP_START     = 3'd3,
        OP_SWITCH    = 3'd4
    } op_t;

    // Per-task scheduling state
    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RUNNING   = 2'd2
    } task_state_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_TASK0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_TASK3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOSTART  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TASK  = 3'd5;

    // Number of tasks that have priority and autostart registers
    localparam int unsigned CFG_TASKS = 4;
    localparam int unsigned PRIO_REG_W = 8;
    localparam int unsigned TASK_OUT_W = 2;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // One result transaction
    typedef struct packed {
        logic                  status;
        logic [TASK_OUT_W-1:0] next_task;
        logic                  switch_request;
        logic [TASK_OUT_W-1:0] running_task;
    } result_t;

endpackage

`default_nettype wire

/* design/priority_task_scheduler.sv */
// Top level of the fixed-priority task scheduler: input register, task
// table, configuration registers and result register. Uses pts_pkg, pts_exec.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | s_valid / s_ready  | s_opcode, s_task_id
//  result   | m_valid / m_ready  | m_status, m_next_task, m_switch_request,
//           |                    | m_running_task
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An operation waits in the input register and moves to the result register
// when that is free or being taken; one operation is accepted every cycle
// while the result is not stalled; the table update and priority tree run between
// the two registers. A stalled result holds the input register, and s_ready drops
// only while both are full. Reset clears the table to all suspended and the
// running and chosen tasks to 0. Configuration is always ready.
`default_nettype none

module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int unsigned TASKS     = 4,
    parameter int unsigned PRIO_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [2:0]            s_opcode,
    input  wire logic [7:0]            s_task_id,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_status,
    output logic [TASK_OUT_W-1:0]      m_next_task,
    output logic                       m_switch_request,
    output logic [TASK_OUT_W-1:0]      m_running_task,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned IDW = (TASKS > 4) ? $clog2(TASKS) : 2;

    // Configuration registers
    logic [CFG_TASKS-1:0][PRIO_REG_W-1:0] prio_reg;
    logic [CFG_TASKS-1:0]                 autostart_reg;
    logic [TASK_OUT_W-1:0]                idle_reg;

    // Input register
    logic        in_valid_reg;
    op_t         op_reg;
    logic [7:0]  id_reg;

    // Scheduler state
    task_state_t [TASKS-1:0] states_reg;
    logic [IDW-1:0]          current_reg;
    logic [IDW-1:0]          chosen_reg;

    // Result register
    logic    out_valid_reg;
    result_t result_reg;

    task_state_t [TASKS-1:0]       states_next;
    logic [IDW-1:0]                current_next;
    logic [IDW-1:0]                chosen_next;
    result_t                       result_next;
    logic [TASKS-1:0][PRIO_BITS-1:0] prio;
    logic                          advance;

    // Move an operation on when the result register is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Effective priority per task; tasks without a register get 0
    always_comb begin
        for (int i = 0; i < TASKS; i++) begin
            if (i < CFG_TASKS) prio[i] = PRIO_BITS'(prio_reg[i % CFG_TASKS]);
            else               prio[i] = '0;
        end
    end

    pts_exec #(
        .TASKS     (TASKS),
        .PRIO_BITS (PRIO_BITS),
        .IDW       (IDW)
    ) u_exec (
        .opcode         (op_reg),
        .task_id        (id_reg),
        .states         (states_reg),
        .current_task   (current_reg),
        .chosen_task    (chosen_reg),
        .prio           (prio),
        .autostart_mask (autostart_reg),
        .idle_task      (IDW'(idle_reg)),
        .states_next    (states_next),
        .current_next   (current_next),
        .chosen_next    (chosen_next),
        .result         (result_next)
    );

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_reg      <= '0;
            autostart_reg <= '0;
            idle_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index <= REG_PRIO_TASK3) begin
                prio_reg[cfg_index[1:0] - REG_PRIO_TASK0[1:0]] <= cfg_data;
            end else if (cfg_index == REG_AUTOSTART) begin
                autostart_reg <= cfg_data[CFG_TASKS-1:0];
            end else if (cfg_index == REG_IDLE_TASK) begin
                idle_reg <= cfg_data[TASK_OUT_W-1:0];
            end
        end
    end

    // Capture an input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_t'(s_opcode);
            id_reg <= s_task_id;
        end
    end

    // Commit table state as the operation advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            states_reg  <= {TASKS{ST_SUSPENDED}};
            current_reg <= '0;
            chosen_reg  <= '0;
        end else if (advance) begin
            states_reg  <= states_next;
            current_reg <= current_next;
            chosen_reg  <= chosen_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = result_reg.status;
    assign m_next_task      = result_reg.next_task;
    assign m_switch_request = result_reg.switch_request;
    assign m_running_task   = result_reg.running_task;

endmodule

`default_nettype wire

/* design/pts_pick.sv */
// Priority selection tree: highest-priority eligible task, ties to the
// higher index, idle task when none is eligible. Uses pts_pkg.
`default_nettype none

module pts_pick
    import pts_pkg::*;
#(
    parameter int unsigned TASKS     = 4,
    parameter int unsigned PRIO_BITS = 8,
    parameter int unsigned IDW       = 2
) (
    input  wire logic [TASKS-1:0]                elig,
    input  wire logic [TASKS-1:0][PRIO_BITS-1:0] prio,
    input  wire logic [IDW-1:0]                  idle_task,
    output logic      [IDW-1:0]                  pick
);

    localparam int unsigned NP = 1 << $clog2(TASKS);

    typedef struct packed {
        logic                 elig;
        logic [PRIO_BITS-1:0] prio;
        logic [IDW-1:0]       idx;
    } node_t;

    node_t nodes [1:2*NP-1];

    // Build the tree: leaves in task order, each node keeps the better child
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            if (i < TASKS) begin
                nodes[NP+i].elig = elig[i];
                nodes[NP+i].prio = prio[i];
            end else begin
                nodes[NP+i].elig = 1'b0;
                nodes[NP+i].prio = '0;
            end
            nodes[NP+i].idx = IDW'(i);
        end
        for (int n = NP - 1; n >= 1; n--) begin
            // right child holds the higher indexes and wins ties
            if (nodes[2*n+1].elig &&
                (!nodes[2*n].elig || nodes[2*n+1].prio >= nodes[2*n].prio)) begin
                nodes[n] = nodes[2*n+1];
            end else begin
                nodes[n] = nodes[2*n];
            end
        end
    end

    assign pick = nodes[1].elig ? nodes[1].idx : idle_task;

endmodule

`default_nettype wire

/* design/pts_exec.sv */
// Operation logic: applies one operation to the task table and, for activate,
// terminate, chain and start, makes the scheduling decision. Uses pts_pkg and pts_pick.
`default_nettype none

module pts_exec
    import pts_pkg::*;
#(
    parameter int unsigned TASKS     = 4,
    parameter int unsigned PRIO_BITS = 8,
    parameter int unsigned IDW       = 2
) (
    input  wire op_t                             opcode,
    input  wire logic [7:0]                      task_id,
    input  wire task_state_t [TASKS-1:0]         states,
    input  wire logic [IDW-1:0]                  current_task,
    input  wire logic [IDW-1:0]                  chosen_task,
    input  wire logic [TASKS-1:0][PRIO_BITS-1:0] prio,
    input  wire logic [CFG_TASKS-1:0]            autostart_mask,
    input  wire logic [IDW-1:0]                  idle_task,
    output task_state_t [TASKS-1:0]              states_next,
    output logic      [IDW-1:0]                  current_next,
    output logic      [IDW-1:0]                  chosen_next,
    output result_t                              result
);

    logic              id_valid;
    logic [TASKS-1:0]  elig;
    logic [IDW-1:0]    pick;
    logic              status;
    logic              decide;

    assign id_valid = task_id < 8'(TASKS);

    // Eligible means ready or running after this operation's state writes
    always_comb begin
        for (int i = 0; i < TASKS; i++) begin
            elig[i] = (states_next[i] == ST_READY) || (states_next[i] == ST_RUNNING);
        end
    end

    pts_pick #(
        .TASKS     (TASKS),
        .PRIO_BITS (PRIO_BITS),
        .IDW       (IDW)
    ) u_pick (
        .elig      (elig),
        .prio      (prio),
        .idle_task (idle_task),
        .pick      (pick)
    );

    // Apply the operation to the table
    always_comb begin
        states_next  = states;
        current_next = current_task;
        decide       = 1'b0;
        status       = STATUS_OK;
        case (opcode)
            OP_ACTIVATE: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (id_valid && task_id == 8'(i)) states_next[i] = ST_READY;
                end
                if (!id_valid) status = STATUS_ERROR;
                decide = 1'b1;
            end
            OP_TERMINATE: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (current_task == IDW'(i)) states_next[i] = ST_SUSPENDED;
                end
                decide = 1'b1;
            end
            OP_CHAIN: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (current_task == IDW'(i)) states_next[i] = ST_SUSPENDED;
                    if (id_valid && task_id == 8'(i)) states_next[i] = ST_READY;
                end
                if (!id_valid) status = STATUS_ERROR;
                decide = 1'b1;
            end
            OP_START: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (i < CFG_TASKS) begin
                        if (autostart_mask[i % CFG_TASKS]) states_next[i] = ST_READY;
                    end
                end
                current_next = idle_task;
                decide       = 1'b1;
            end
            OP_SWITCH: begin
                // old task back to ready, then the chosen one runs
                for (int i = 0; i < TASKS; i++) begin
                    if (current_task == IDW'(i) && states[i] == ST_RUNNING) begin
                        states_next[i] = ST_READY;
                    end
                    if (chosen_task == IDW'(i)) states_next[i] = ST_RUNNING;
                end
                current_next = chosen_task;
            end
            default: begin
                status = STATUS_ERROR;
            end
        endcase
    end

    // Take the new pick only for operations that make a decision
    assign chosen_next = decide ? pick : chosen_task;

    // Assemble the result transaction
    always_comb begin
        result.status         = status;
        result.next_task      = chosen_next[TASK_OUT_W-1:0];
        result.switch_request = chosen_next != current_next;
        result.running_task   = current_next[TASK_OUT_W-1:0];
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for priority_task_scheduler: random and directed operations are
// checked against a scheduling predictor kept inside this file.
// Depends on pts_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS = 250;
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST = 3'd7;
    localparam logic [7:0] ID_MAX = 8'hFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_opcode = '0;
    logic [7:0] s_task_id = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic [TASK_OUT_W-1:0] m_next_task;
    logic m_switch_request;
    logic [TASK_OUT_W-1:0] m_running_task;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: task table, running and chosen task, register copies
    task_state_t task_tbl [CFG_TASKS];
    logic [1:0] run_task = '0;
    logic [1:0] pick_task = '0;
    logic [1:0] idle_id = '0;
    logic [7:0] prio_reg [CFG_TASKS];
    logic [3:0] auto_mask = '0;

    result_t pending_decisions [$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_request = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    priority_task_scheduler u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_task_id        (s_task_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_next_task      (m_next_task),
        .m_switch_request (m_switch_request),
        .m_running_task   (m_running_task),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        for (int i = 0; i < CFG_TASKS; i++) begin
            task_tbl[i] = ST_SUSPENDED;
            prio_reg[i] = '0;
        end
    end

    // Highest-priority eligible task, ties to the higher index, else idle
    function automatic logic [1:0] highest_eligible();
        logic [1:0] best;
        logic [7:0] top;
        best = idle_id;
        top = '0;
        for (int i = 0; i < CFG_TASKS; i++) begin
            if ((task_tbl[i] == ST_READY || task_tbl[i] == ST_RUNNING) && prio_reg[i] >= top) begin
                top = prio_reg[i];
                best = i[1:0];
            end
        end
        return best;
    endfunction

    // Apply one operation to the predicted table and return its result
    function automatic result_t schedule_op(input logic [2:0] op, input logic [7:0] id);
        result_t r;
        logic id_ok;
        id_ok = (id < CFG_TASKS);
        r.status = STATUS_OK;
        case (op)
            OP_ACTIVATE: begin
                if (id_ok) task_tbl[id[1:0]] = ST_READY;
                else r.status = STATUS_ERROR;
                pick_task = highest_eligible();
            end
            OP_TERMINATE: begin
                task_tbl[run_task] = ST_SUSPENDED;
                pick_task = highest_eligible();
            end
            OP_CHAIN: begin
                task_tbl[run_task] = ST_SUSPENDED;
                if (id_ok) task_tbl[id[1:0]] = ST_READY;
                else r.status = STATUS_ERROR;
                pick_task = highest_eligible();
            end
            OP_START: begin
                for (int i = 0; i < CFG_TASKS; i++)
                    if (auto_mask[i]) task_tbl[i] = ST_READY;
                run_task = idle_id;
                pick_task = highest_eligible();
            end
            OP_SWITCH: begin
                if (task_tbl[run_task] == ST_RUNNING) task_tbl[run_task] = ST_READY;
                run_task = pick_task;
                task_tbl[run_task] = ST_RUNNING;
            end
            default: begin
                r.status = STATUS_ERROR;
            end
        endcase
        r.next_task = pick_task;
        r.switch_request = (pick_task != run_task);
        r.running_task = run_task;
        return r;
    endfunction

    // Offer one operation, hold it until accepted, then predict its result
    task automatic send_op(input logic [2:0] op, input logic [7:0] id);
        int unsigned gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_task_id <= id;
        do @(posedge aclk); while (!s_ready);
        pending_decisions.push_back(schedule_op(op, id));
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_PRIO_TASK3) prio_reg[idx[1:0]] = val;
        else if (idx == REG_AUTOSTART) auto_mask = val[3:0];
        else if (idx == REG_IDLE_TASK) idle_id = val[1:0];
    endtask

    // Write all registers; called only with the block idle
    task automatic load_config(input logic [CFG_TASKS-1:0][7:0] prios, input logic [3:0] mask,
                               input logic [1:0] idle);
        for (int i = 0; i < CFG_TASKS; i++)
            write_reg(REG_PRIO_TASK0 + CFG_IDX_W'(i), prios[i]);
        write_reg(REG_AUTOSTART, {4'b0, mask});
        write_reg(REG_IDLE_TASK, {6'b0, idle});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_prio();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return ID_MAX;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed operations on valid tasks, with some noise
    task automatic send_random_op();
        int unsigned roll;
        logic [2:0] op;
        logic [7:0] id;
        roll = $urandom_range(0, 99);
        if (roll < 32) op = OP_ACTIVATE;
        else if (roll < 60) op = OP_SWITCH;
        else if (roll < 72) op = OP_TERMINATE;
        else if (roll < 87) op = OP_CHAIN;
        else if (roll < 95) op = OP_START;
        else op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        if ($urandom_range(0, 9) == 0) id = 8'($urandom_range(0, 255));
        else id = 8'($urandom_range(0, CFG_TASKS - 1));
        send_op(op, id);
    endtask

    // Reset defaults, bad opcodes, bad ids, ties, chain and terminate paths
    task automatic test_directed();
        send_op(OP_START, 8'd0);
        send_op(OP_SWITCH, ID_MAX);
        wait_drain();
        load_config({8'd0, 8'd200, 8'd200, 8'd10}, 4'b1001, 2'd3);
        for (logic [3:0] op = {1'b0, OP_BAD_FIRST}; op <= {1'b0, OP_BAD_LAST}; op++)
            send_op(op[2:0], 8'd1);
        send_op(OP_ACTIVATE, 8'(CFG_TASKS));
        send_op(OP_ACTIVATE, ID_MAX);
        send_op(OP_START, 8'd0);
        send_op(OP_SWITCH, 8'd0);
        send_op(OP_ACTIVATE, 8'd1);
        send_op(OP_ACTIVATE, 8'd2);
        send_op(OP_SWITCH, 8'd0);
        send_op(OP_ACTIVATE, 8'd2);
        send_op(OP_CHAIN, 8'h80);
        send_op(OP_SWITCH, 8'd0);
        send_op(OP_CHAIN, 8'd0);
        send_op(OP_SWITCH, 8'd0);
        send_op(OP_TERMINATE, 8'd0);
        send_op(OP_SWITCH, 8'd0);
        send_op(OP_TERMINATE, 8'd0);
        send_op(OP_TERMINATE, 8'd0);
        send_op(OP_ACTIVATE, 8'd0);
        wait_drain();
    endtask

    // Several register settings, extremes first, random traffic in each
    task automatic test_random_configs();
        logic [CFG_TASKS-1:0][7:0] prios;
        logic [3:0] mask;
        for (int phase = 0; phase < 7; phase++) begin
            for (int i = 0; i < CFG_TASKS; i++)
                prios[i] = (phase == 0) ? 8'd0 : (phase == 1) ? ID_MAX : rand_prio();
            mask = (phase == 0) ? 4'h0 : (phase == 1) ? 4'hF : 4'($urandom_range(0, 15));
            load_config(prios, mask, 2'(phase));
            send_op(OP_START, 8'd0);
            repeat (PHASE_ITEMS) send_random_op();
            wait_drain();
        end
    endtask

    // Hold the result side for a long stretch while operations keep coming
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_request = 300;
        repeat (60) send_random_op();
        wait_drain();
        src_idle_on = 1'b1;
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        repeat (150) send_random_op();
        wait_drain();
    endtask

    // Result side ready control: long hold on request, else random bursts
    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decisions.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status=%0d next=%0d switch=%0d running=%0d",
                             m_status, m_next_task, m_switch_request, m_running_task);
            end else begin
                want = pending_decisions.pop_front();
                if (m_status !== want.status || m_next_task !== want.next_task ||
                    m_switch_request !== want.switch_request ||
                    m_running_task !== want.running_task) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("mismatch: expected status=%0d next=%0d switch=%0d running=%0d,",
                               want.status, want.next_task, want.switch_request,
                               want.running_task);
                        $display(" got status=%0d next=%0d switch=%0d running=%0d",
                                 m_status, m_next_task, m_switch_request, m_running_task);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : run_tests
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_configs();
        test_backpressure();
        test_full_rate();
        fail_count += pending_decisions.size();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/pts_pkg.sv
design/pts_pick.sv
design/pts_exec.sv
design/priority_task_scheduler.sv
sim/testbench.sv
